### hw/rtl/lpc3_pkg.sv
package lpc3_pkg;

    localparam int PIX_IN_W   = 16;
    localparam int CFG_W      = 11;
    localparam int COUNT_W    = 20;
    localparam int PEAKS_W    = 21;
    localparam int M_DATA_W   = 24;
    localparam int MIN_SIZE   = 3;
    localparam int QUEUE_DEPTH = 3;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic               frame_done;
        logic [COUNT_W-1:0] peak_count;
        logic               is_peak;
        logic               centre_valid;
    } out_word_t;

endpackage

### hw/rtl/local_peak_counter_3x3_core.sv
// Strict 3x3 local maximum detector and peak counter for a raster-scanned frame. Pixels
// enter on the s_ channel; each accepted pixel gives exactly one result word on the m_ channel
// via stage 1 and the output queue, carrying whether an interior centre was judged (tuser),
// whether it is a peak and the running peak count (tdata), and the frame end (tlast), after
// which the count and position restart. The two previous rows live in one simple dual-port
// RAM of MAX_WIDTH words, each holding the upper and middle row samples of a column; a pixel
// reads its column at acceptance and writes it back from stage 1; consecutive pixels always
// touch different columns, so no forwarding is needed. Sustained throughput is one pixel per
// clock while m_tready is high, set by the single read and single write port of that RAM; a
// three-word output queue holds words while m_ stalls. The image width and height registers
// (reset 10) are clamped in use to 3..MAX_WIDTH and 3..MAX_HEIGHT; the user must write them
// only while the block is idle; the block does not enforce it.
module local_peak_counter_3x3_core
    import lpc3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PIX_IN_W-1:0] s_tdata,   // [15:0] pixel_value

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [0] is_peak, [20:1] peak_count, [23:21] zero
    output logic                m_tuser,   // [0] centre_valid
    output logic                m_tlast    // frame_done
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int YW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam int PB = PIXEL_BITS;
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);

    // configuration
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    logic [XW-1:0] w_ext, w_eff;
    logic [YW-1:0] h_ext, h_eff;

    assign w_ext = XW'(width_reg);
    assign h_ext = YW'(height_reg);
    assign w_eff = (w_ext < XW'(MIN_SIZE))  ? XW'(MIN_SIZE)  :
                   (w_ext > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_ext;
    assign h_eff = (h_ext < YW'(MIN_SIZE))   ? YW'(MIN_SIZE)   :
                   (h_ext > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : h_ext;

    // handshakes
    logic          s_accept, m_accept;
    logic [QW-1:0] q_count_reg, q_count_next;
    logic          v1_reg;

    assign s_accept = s_tvalid & s_tready;
    assign m_accept = m_tvalid & m_tready;
    assign s_tready = ((QW+1)'(q_count_reg) + (QW+1)'(v1_reg)) < (QW+1)'(QUEUE_DEPTH);

    // stage 0: position tracking and line buffer read
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row, done0, cv0;
    logic [PB-1:0] pix0;

    always_comb begin
        pix0 = '0;
        for (int i = 0; i < PB; i++) begin
            if (i < PIX_IN_W) begin
                pix0[i] = s_tdata[i];
            end
        end
    end

    assign last_col = (XW'(col_reg) + XW'(1)) >= w_eff;
    assign last_row = (YW'(row_reg) + YW'(1)) >= h_eff;
    assign done0    = last_col & last_row;
    assign cv0      = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (done0) begin
                col_next = '0;
                row_next = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = RW'(row_reg + RW'(1));
            end else begin
                col_next = CW'(col_reg + CW'(1));
            end
        end
    end

    // line buffer: low half upper row, high half middle row
    logic [2*PB-1:0] lb_mem [MAX_WIDTH];
    logic [2*PB-1:0] rd_word_reg;
    logic [CW-1:0]   idx1_reg;
    logic [PB-1:0]   pix1_reg;
    logic            cv1_reg, done1_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_word_reg <= lb_mem[col_reg];
            idx1_reg    <= col_reg;
            pix1_reg    <= pix0;
            cv1_reg     <= cv0;
            done1_reg   <= done0;
        end
    end

    // stage 1: window update, peak test, write back
    logic [PB-1:0] top_a_reg, top_b_reg, mid_a_reg, mid_b_reg, bot_a_reg, bot_b_reg;
    logic [PB-1:0] rd_upper, rd_middle;
    logic          peak1;
    logic [PEAKS_W-1:0] peaks_reg, peaks_next, peaks_inc;
    out_word_t     push_word;

    assign rd_upper  = rd_word_reg[PB-1:0];
    assign rd_middle = rd_word_reg[2*PB-1:PB];

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            lb_mem[idx1_reg] <= {pix1_reg, rd_middle};
            top_a_reg <= top_b_reg;
            top_b_reg <= rd_upper;
            mid_a_reg <= mid_b_reg;
            mid_b_reg <= rd_middle;
            bot_a_reg <= bot_b_reg;
            bot_b_reg <= pix1_reg;
        end
    end

    // centre of the shifted window is the previous middle-row sample
    assign peak1 = cv1_reg
                 && (top_a_reg < mid_b_reg) && (top_b_reg < mid_b_reg)
                 && (rd_upper  < mid_b_reg) && (mid_a_reg < mid_b_reg)
                 && (rd_middle < mid_b_reg) && (bot_a_reg < mid_b_reg)
                 && (bot_b_reg < mid_b_reg) && (pix1_reg  < mid_b_reg);

    assign peaks_inc = peak1 ? PEAKS_W'(peaks_reg + PEAKS_W'(1)) : peaks_reg;

    always_comb begin
        peaks_next = peaks_reg;
        if (v1_reg) begin
            peaks_next = done1_reg ? '0 : peaks_inc;
        end
    end

    always_comb begin
        push_word.centre_valid = cv1_reg;
        push_word.is_peak      = peak1;
        push_word.peak_count   = peaks_inc[COUNT_W-1:0];
        push_word.frame_done   = done1_reg;
    end

    // output queue
    out_word_t     q_mem [QUEUE_DEPTH];
    logic [PW-1:0] q_wr_ptr_reg, q_wr_ptr_next, q_rd_ptr_reg, q_rd_ptr_next;
    out_word_t     head_word;

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            q_mem[q_wr_ptr_reg] <= push_word;
        end
    end

    always_comb begin
        q_wr_ptr_next = q_wr_ptr_reg;
        q_rd_ptr_next = q_rd_ptr_reg;
        if (v1_reg) begin
            q_wr_ptr_next = (q_wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                          : PW'(q_wr_ptr_reg + PW'(1));
        end
        if (m_accept) begin
            q_rd_ptr_next = (q_rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0
                          : PW'(q_rd_ptr_reg + PW'(1));
        end
        q_count_next = QW'(q_count_reg + QW'(v1_reg) - QW'(m_accept));
    end

    assign head_word = q_mem[q_rd_ptr_reg];
    assign m_tvalid  = (q_count_reg != '0);
    assign m_tdata   = M_DATA_W'({head_word.peak_count, head_word.is_peak});
    assign m_tuser   = head_word.centre_valid;
    assign m_tlast   = head_word.frame_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= CFG_W'(10);
            height_reg   <= CFG_W'(10);
            col_reg      <= '0;
            row_reg      <= '0;
            v1_reg       <= 1'b0;
            peaks_reg    <= '0;
            q_count_reg  <= '0;
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            v1_reg       <= s_accept;
            peaks_reg    <= peaks_next;
            q_count_reg  <= q_count_next;
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
        end
    end

    // no read of a column while the same column is being written back
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && s_accept) |-> (col_reg != idx1_reg))
        else $error("line buffer read and write hit the same column");

    // queue never holds more than its depth, counting the word in flight
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((QW+1)'(q_count_reg) + (QW+1)'(v1_reg)) <= (QW+1)'(QUEUE_DEPTH))
        else $error("output queue overflow");

    // a peak is only reported for a judged centre
    a_peak_needs_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tuser)
        else $error("peak word without a judged centre");

    // the count restarts after the frame end word is pushed
    a_count_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && done1_reg) |=> (peaks_reg == '0))
        else $error("peak count not cleared at frame end");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import lpc3_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int NEIGHBOURS = 8;

    typedef enum int {
        FILL_WIDE,
        FILL_TIES,
        FILL_EXTREME,
        FILL_PLANTED
    } fill_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [PIX_IN_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    logic [PIX_IN_W-1:0] pixel_queue[$];
    out_word_t           judged_words[$];
    int                  words_owed = 0;
    logic                in_taken = 1'b0;
    int unsigned         idle_pct = 31;
    int unsigned         mismatches = 0;

    // shadow of the block's state
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [PIX_IN_W-1:0] upper_row [MAX_W];
    logic [PIX_IN_W-1:0] middle_row [MAX_W];
    logic [PIX_IN_W-1:0] win [9];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [PEAKS_W-1:0]  peaks;

    local_peak_counter_3x3_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic out_word_t judge_pixel(logic [PIX_IN_W-1:0] pix);
        out_word_t   res;
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int          below;
        logic        last_col;
        logic        last_row;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        slot = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = upper_row[slot];
        win[5] = middle_row[slot];
        win[8] = pix;
        res = '0;
        if (row_pos >= 2 && col_pos >= 2) begin
            res.centre_valid = 1'b1;
            below = 0;
            for (int k = 0; k < 9; k++)
                if (k != 4 && win[k] < win[4]) below++;
            if (below == NEIGHBOURS) begin
                res.is_peak = 1'b1;
                peaks = peaks + 1'b1;
            end
        end
        upper_row[slot]  = middle_row[slot];
        middle_row[slot] = pix;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        res.peak_count = peaks[COUNT_W-1:0];
        res.frame_done = last_col && last_row;
        if (res.frame_done) begin
            col_pos = 0;
            row_pos = 0;
            peaks = '0;
        end else if (last_col) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    task automatic log_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // driver: pixels out and result backpressure, both at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || in_taken) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // monitor: predict on every accepted pixel, check every accepted word
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            width_reg  = CFG_W'(10);
            height_reg = CFG_W'(10);
            for (int i = 0; i < MAX_W; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            peaks   = '0;
            judged_words.delete();
            words_owed <= 0;
            in_taken   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_IMAGE_HEIGHT)
                    height_reg = pwdata[CFG_W-1:0];
                else
                    width_reg = pwdata[CFG_W-1:0];
            end
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                judged_words.push_back(judge_pixel(s_tdata));
            if (m_tvalid && m_tready) begin
                if (judged_words.size() == 0) begin
                    log_mismatch("word with no pixel pending", 1, 0);
                end else begin
                    want = judged_words.pop_front();
                    if (m_tuser !== want.centre_valid)
                        log_mismatch("centre_valid", m_tuser, want.centre_valid);
                    if (m_tdata[0] !== want.is_peak)
                        log_mismatch("is_peak", m_tdata[0], want.is_peak);
                    if (m_tdata[COUNT_W:1] !== want.peak_count)
                        log_mismatch("peak_count", m_tdata[COUNT_W:1], want.peak_count);
                    if (m_tdata[M_DATA_W-1:COUNT_W+1] !== '0)
                        log_mismatch("tdata padding", m_tdata[M_DATA_W-1:COUNT_W+1], 0);
                    if (m_tlast !== want.frame_done)
                        log_mismatch("frame_done", m_tlast, want.frame_done);
                end
            end
            words_owed <= words_owed + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
        end
    end

    task automatic wait_drained();
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || words_owed != 0);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [PIX_IN_W-1:0] next_pixel(fill_t fill);
        case (fill)
            FILL_TIES:    return PIX_IN_W'($urandom_range(0, 3));
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return 16'h0001;
                    2: return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
            end
            FILL_PLANTED: begin
                if ($urandom_range(0, 99) < 15)
                    return 16'hFFFF - PIX_IN_W'($urandom_range(0, 3));
                return PIX_IN_W'($urandom_range(0, 255));
            end
            default:      return PIX_IN_W'($urandom());
        endcase
    endfunction

    task automatic queue_frame(int unsigned w, int unsigned h, fill_t fill,
                               int unsigned hold_at);
        for (int unsigned i = 0; i < w * h; i++) begin
            if (hold_at != 0 && i == hold_at) wait_drained();
            pixel_queue.push_back(next_pixel(fill));
        end
    endtask

    initial begin
        logic [PIX_IN_W-1:0] px;
        logic [31:0]         wv;
        logic [31:0]         hv;
        int unsigned         w;
        int unsigned         h;
        int unsigned         frames;
        int unsigned         phase;
        int unsigned         small_items;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size 10x10: one peak at row 1 column 1, then shrink mid-frame
        for (int i = 0; i < 23; i++) begin
            case (i)
                5:       px = 16'h0001;
                11:      px = 16'hFFFF;
                15, 16:  px = 16'h8000;
                18:      px = 16'hFFFF;
                20:      px = 16'hFFFE;
                22:      px = 16'h7FFF;
                default: px = 16'h0000;
            endcase
            pixel_queue.push_back(px);
        end
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        pixel_queue.push_back(16'h0000);
        wv = 32'd2;
        hv = 32'd1;

        phase = 0;
        small_items = 0;
        while (small_items < 650) begin
            wait_drained();
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                wv = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) wv = wv | ($urandom() & 32'hFFFF_F800);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                hv = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0) hv = hv | ($urandom() & 32'hFFFF_F800);
            end
            write_reg(REG_IMAGE_WIDTH, wv);
            write_reg(REG_IMAGE_HEIGHT, hv);
            w = clamp_size(wv[CFG_W-1:0], MAX_W);
            h = clamp_size(hv[CFG_W-1:0], MAX_H);
            idle_pct = (phase == 2) ? 0 : 31;
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                queue_frame(w, h, fill_t'($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h - 1) : 0);
            end
            small_items += w * h * frames;
            phase++;
        end

        wait_drained();
        idle_pct = 31;
        repeat (20) @(posedge aclk);
        if (judged_words.size() != 0)
            log_mismatch("words never delivered", 0, judged_words.size());
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lpc3_pkg.sv
hw/rtl/local_peak_counter_3x3_core.sv
verif/tb.sv
